// File: rtl/tsrr_pkg.sv
// Shared widths, configuration register indexes, types and the slice function of the scheduler.
package tsrr_pkg;

    localparam int MAX_TASKS_DEF = 4;

    localparam int TC_W       = 3;
    localparam int PRIO_W     = 12;
    localparam int EN_W       = 4;
    localparam int PRIO_BITS  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TIME_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int SLICE_W    = 3;
    localparam int TASK_OUT_W = 2;
    localparam int SLICE_BASE = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_TABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK    = 2'd2;

    localparam logic [TC_W-1:0]   TASK_COUNT_RST     = 3'd4;
    localparam logic [PRIO_W-1:0] PRIORITY_TABLE_RST = 12'd0;
    localparam logic [EN_W-1:0]   ENABLE_MASK_RST    = 4'hF;

    typedef enum logic
    {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Write strobes into the per-task accounting file.
    typedef struct packed
    {
        logic start_all;
        logic start_we;
        logic total_we;
        logic count_we;
    } tf_wr_t;

    // Slice length: base minus priority mod base.
    function automatic logic [SLICE_W-1:0] slice_of(input logic [PRIO_BITS-1:0] prio);
        logic [PRIO_BITS-1:0] m;
        m = (prio >= PRIO_BITS'(SLICE_BASE)) ? prio - PRIO_BITS'(SLICE_BASE) : prio;
        return SLICE_W'(SLICE_BASE) - SLICE_W'(m);
    endfunction

endpackage

// File: rtl/tsrr_if.sv
// Tick and result channel interfaces of the scheduler.
interface tsrr_tick_if;
    logic                        valid;
    logic                        ready;
    logic                        force_switch;
    logic [tsrr_pkg::TIME_W-1:0] tick_time;

    modport source (output valid, force_switch, tick_time, input ready);
    modport sink   (input valid, force_switch, tick_time, output ready);
endinterface

interface tsrr_result_if;
    logic                            valid;
    logic                            ready;
    logic [tsrr_pkg::TASK_OUT_W-1:0] running_task;
    logic                            switched;
    logic [tsrr_pkg::TASK_OUT_W-1:0] outgoing_task;
    logic [tsrr_pkg::SLICE_W-1:0]    slice_remaining;
    logic [tsrr_pkg::TIME_W-1:0]     outgoing_run_total;
    logic [tsrr_pkg::COUNT_W-1:0]    outgoing_switch_count;

    modport source (output valid, running_task, switched, outgoing_task, slice_remaining,
                    outgoing_run_total, outgoing_switch_count, input ready);
    modport sink   (input valid, running_task, switched, outgoing_task, slice_remaining,
                    outgoing_run_total, outgoing_switch_count, output ready);
endinterface

// File: rtl/tsrr_alu.sv
// Shared 64-bit add/subtract unit used by the accounting steps.
module tsrr_alu
(
    input  logic [tsrr_pkg::TIME_W-1:0] a,
    input  logic [tsrr_pkg::TIME_W-1:0] b,
    input  tsrr_pkg::alu_op_t           op,
    output logic [tsrr_pkg::TIME_W-1:0] y
);

    logic                        is_sub;
    logic [tsrr_pkg::TIME_W-1:0] b_eff;

    assign is_sub = (op == tsrr_pkg::ALU_SUB);
    // Subtract as add of the complement with carry in.
    assign b_eff  = is_sub ? ~b : b;
    assign y      = a + b_eff + tsrr_pkg::TIME_W'(is_sub);

endmodule

// File: rtl/tsrr_task_file.sv
// Per-task start times, run totals and switch-out counts, one read port.
module tsrr_task_file
#(
    parameter int MAX_TASKS = tsrr_pkg::MAX_TASKS_DEF,
    localparam int TASK_W = $clog2(MAX_TASKS)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsrr_pkg::tf_wr_t             wr,
    input  logic [TASK_W-1:0]            rd_idx,
    input  logic [TASK_W-1:0]            start_idx,
    input  logic [tsrr_pkg::TIME_W-1:0]  wr_time,
    input  logic [tsrr_pkg::TIME_W-1:0]  wr_total,
    input  logic [tsrr_pkg::COUNT_W-1:0] wr_count,
    output logic [tsrr_pkg::TIME_W-1:0]  rd_start,
    output logic [tsrr_pkg::TIME_W-1:0]  rd_total,
    output logic [tsrr_pkg::COUNT_W-1:0] rd_count
);

    logic [tsrr_pkg::TIME_W-1:0]  start_reg [MAX_TASKS];
    logic [tsrr_pkg::TIME_W-1:0]  total_reg [MAX_TASKS];
    logic [tsrr_pkg::COUNT_W-1:0] count_reg [MAX_TASKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                start_reg[i] <= '0;
                total_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                if (wr.start_all || (wr.start_we && start_idx == TASK_W'(i)))
                begin
                    start_reg[i] <= wr_time;
                end
            end
            if (wr.total_we)
            begin
                total_reg[rd_idx] <= wr_total;
            end
            if (wr.count_we)
            begin
                count_reg[rd_idx] <= wr_count;
            end
        end
    end

    assign rd_start = start_reg[rd_idx];
    assign rd_total = total_reg[rd_idx];
    assign rd_count = count_reg[rd_idx];

endmodule

// File: rtl/time_slice_round_robin_scheduler_core.sv
// Round-robin time-slice scheduler: sequencer, configuration and result register.
//
//  channel  | dir | beat payload                                       | handshake
//  ---------+-----+----------------------------------------------------+-------------
//  tick     | in  | force_switch, tick_time                            | valid/ready
//  result   | out | running_task, switched, outgoing_task,             | valid/ready
//           |     | slice_remaining, outgoing_run_total, ..switch_count|
//  cfg      | in  | cfg_index, cfg_data                                | cfg_we only
//
// A tick without reschedule runs accept, slice and result; the first tick adds start. A
// reschedule adds index wrap and a scan of at most the clamped slot count (at most
// MAX_TASKS) candidates, one per cycle; a switch adds diff, accumulate, count and swap, in
// which the shared 64-bit adder forms the run time, the new total and the new switch count.
// Ready is high only while the sequencer is idle; a held result stalls the sequencer
// at its last step, so no tick is taken until the result register frees.
// Reset clears all task accounting at once; no clearing pass.
module time_slice_round_robin_scheduler_core
#(
    parameter int MAX_TASKS = tsrr_pkg::MAX_TASKS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsrr_pkg::CFG_DATA_W-1:0] cfg_data,
    tsrr_tick_if.sink                       tick,
    tsrr_result_if.source                   result
);

    localparam int TASK_W = $clog2(MAX_TASKS);
    localparam int TC_W   = tsrr_pkg::TC_W;
    localparam logic [TC_W-1:0] N_CAP = (MAX_TASKS > 7) ? 3'd7 : TC_W'(MAX_TASKS);

    typedef enum logic [9:0]
    {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_SLICE = 10'b0000000100,
        S_NORM  = 10'b0000001000,
        S_CHECK = 10'b0000010000,
        S_DIFF  = 10'b0000100000,
        S_ACC   = 10'b0001000000,
        S_CNT   = 10'b0010000000,
        S_SWAP  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 started_reg, started_next;
    logic [TASK_W-1:0]                    current_reg, current_next;
    logic [TASK_W-1:0]                    outgoing_reg, outgoing_next;
    logic [tsrr_pkg::SLICE_W-1:0]         slice_reg, slice_next;
    logic [TC_W-1:0]                      cand_reg, cand_next;
    logic [TC_W-1:0]                      k_reg, k_next;
    logic                                 switched_reg, switched_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [TC_W-1:0]                      task_count_reg;
    logic [tsrr_pkg::PRIO_W-1:0]          priority_reg;
    logic [tsrr_pkg::EN_W-1:0]            enable_reg;

    logic                                 force_reg;
    logic [tsrr_pkg::TIME_W-1:0]          now_reg;
    logic [tsrr_pkg::TIME_W-1:0]          diff_reg;
    logic [tsrr_pkg::TASK_OUT_W-1:0]      out_running_reg;
    logic                                 out_switched_reg;
    logic [tsrr_pkg::TASK_OUT_W-1:0]      out_outgoing_reg;
    logic [tsrr_pkg::SLICE_W-1:0]         out_slice_reg;
    logic [tsrr_pkg::TIME_W-1:0]          out_total_reg;
    logic [tsrr_pkg::COUNT_W-1:0]         out_count_reg;

    logic                                 accept;
    logic                                 load_out;
    logic [TC_W-1:0]                      n_eff;
    logic [TC_W-1:0]                      cur3;
    logic                                 cand_en;

    logic [tsrr_pkg::TIME_W-1:0]          alu_a, alu_b, alu_y;
    tsrr_pkg::alu_op_t                    alu_op;
    tsrr_pkg::tf_wr_t                     tf_wr;
    logic [tsrr_pkg::TIME_W-1:0]          rd_start, rd_total;
    logic [tsrr_pkg::COUNT_W-1:0]         rd_count;

    function automatic logic [tsrr_pkg::PRIO_BITS-1:0] prio_of(
        input logic [TC_W-1:0]               c,
        input logic [tsrr_pkg::PRIO_W-1:0]   tbl
    );
        logic [tsrr_pkg::PRIO_BITS-1:0] p;
        case (c)
            3'd0:    p = tbl[2:0];
            3'd1:    p = tbl[5:3];
            3'd2:    p = tbl[8:6];
            3'd3:    p = tbl[11:9];
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic task_enabled(
        input logic [TC_W-1:0]             c,
        input logic [tsrr_pkg::EN_W-1:0]   mask
    );
        return (c < TC_W'(tsrr_pkg::EN_W)) && mask[c[1:0]];
    endfunction

    assign accept   = tick.valid && tick.ready;
    assign cur3     = TC_W'(current_reg);
    assign cand_en  = task_enabled(cand_reg, enable_reg);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Clamp the slot count to 1..MAX_TASKS, and to at most 7.
    always_comb
    begin
        if (task_count_reg == '0)
        begin
            n_eff = TC_W'(1);
        end
        else if (task_count_reg > N_CAP)
        begin
            n_eff = N_CAP;
        end
        else
        begin
            n_eff = task_count_reg;
        end
    end

    tsrr_alu u_alu
    (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    tsrr_task_file #(.MAX_TASKS(MAX_TASKS)) u_task_file
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tf_wr),
        .rd_idx    (outgoing_reg),
        .start_idx (TASK_W'(cand_reg)),
        .wr_time   (now_reg),
        .wr_total  (alu_y),
        .wr_count  (alu_y[tsrr_pkg::COUNT_W-1:0]),
        .rd_start  (rd_start),
        .rd_total  (rd_total),
        .rd_count  (rd_count)
    );

    always_comb
    begin
        alu_a  = rd_total;
        alu_b  = diff_reg;
        alu_op = tsrr_pkg::ALU_ADD;
        case (state_reg)
            S_DIFF:
            begin
                alu_a  = now_reg;
                alu_b  = rd_start;
                alu_op = tsrr_pkg::ALU_SUB;
            end
            S_CNT:
            begin
                alu_a  = tsrr_pkg::TIME_W'(rd_count);
                alu_b  = tsrr_pkg::TIME_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        current_next   = current_reg;
        outgoing_next  = outgoing_reg;
        slice_next     = slice_reg;
        cand_next      = cand_reg;
        k_next         = k_reg;
        switched_next  = switched_reg;
        out_valid_next = out_valid_reg && !result.ready;
        tf_wr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    outgoing_next = current_reg;
                    switched_next = 1'b0;
                    state_next    = started_reg ? S_SLICE : S_START;
                end
            end
            S_START:
            begin
                tf_wr.start_all = 1'b1;
                slice_next      = tsrr_pkg::slice_of(prio_of(cur3, priority_reg));
                started_next    = 1'b1;
                state_next      = S_SLICE;
            end
            S_SLICE:
            begin
                // A slice already at zero counts as expired and does not wrap.
                slice_next = (slice_reg == '0) ? '0 : slice_reg - 1'b1;
                if (slice_reg <= tsrr_pkg::SLICE_W'(1) || force_reg)
                begin
                    cand_next  = cur3 + 1'b1;
                    k_next     = '0;
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_NORM:
            begin
                // Reduce the first candidate modulo the slot count.
                if (cand_reg >= n_eff)
                begin
                    cand_next = cand_reg - n_eff;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cand_en)
                begin
                    if (cand_reg == cur3)
                    begin
                        slice_next = tsrr_pkg::slice_of(prio_of(cur3, priority_reg));
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
                else if (k_reg == n_eff - 1'b1)
                begin
                    // Nothing runnable: keep the current task.
                    slice_next = tsrr_pkg::slice_of(prio_of(cur3, priority_reg));
                    state_next = S_DONE;
                end
                else
                begin
                    k_next    = k_reg + 1'b1;
                    cand_next = (cand_reg + 1'b1 == n_eff) ? '0 : cand_reg + 1'b1;
                end
            end
            S_DIFF:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                tf_wr.total_we = 1'b1;
                state_next     = S_CNT;
            end
            S_CNT:
            begin
                // Saturate the switch-out count.
                tf_wr.count_we = (rd_count != '1);
                state_next     = S_SWAP;
            end
            S_SWAP:
            begin
                tf_wr.start_we = 1'b1;
                slice_next     = tsrr_pkg::slice_of(prio_of(cand_reg, priority_reg));
                current_next   = TASK_W'(cand_reg);
                switched_next  = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            current_reg    <= '0;
            outgoing_reg   <= '0;
            slice_reg      <= '0;
            cand_reg       <= '0;
            k_reg          <= '0;
            switched_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            task_count_reg <= tsrr_pkg::TASK_COUNT_RST;
            priority_reg   <= tsrr_pkg::PRIORITY_TABLE_RST;
            enable_reg     <= tsrr_pkg::ENABLE_MASK_RST;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            current_reg   <= current_next;
            outgoing_reg  <= outgoing_next;
            slice_reg     <= slice_next;
            cand_reg      <= cand_next;
            k_reg         <= k_next;
            switched_reg  <= switched_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tsrr_pkg::CFG_TASK_COUNT:     task_count_reg <= cfg_data[TC_W-1:0];
                    tsrr_pkg::CFG_PRIORITY_TABLE: priority_reg   <= cfg_data;
                    tsrr_pkg::CFG_ENABLE_MASK:    enable_reg     <= cfg_data[tsrr_pkg::EN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            force_reg <= tick.force_switch;
            now_reg   <= tick.tick_time;
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= alu_y;
        end
        if (load_out)
        begin
            out_running_reg  <= tsrr_pkg::TASK_OUT_W'(current_reg);
            out_switched_reg <= switched_reg;
            out_outgoing_reg <= tsrr_pkg::TASK_OUT_W'(outgoing_reg);
            out_slice_reg    <= slice_reg;
            out_total_reg    <= rd_total;
            out_count_reg    <= rd_count;
        end
    end

    assign tick.ready                   = (state_reg == S_IDLE);
    assign result.valid                 = out_valid_reg;
    assign result.running_task          = out_running_reg;
    assign result.switched              = out_switched_reg;
    assign result.outgoing_task         = out_outgoing_reg;
    assign result.slice_remaining       = out_slice_reg;
    assign result.outgoing_run_total    = out_total_reg;
    assign result.outgoing_switch_count = out_count_reg;

endmodule

// File: rtl/tsrr_checker.sv
// Port-level assertions for the scheduler core and their bind.
module tsrr_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            tick_valid,
    input logic                            tick_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [tsrr_pkg::TASK_OUT_W-1:0] running_task,
    input logic                            switched,
    input logic [tsrr_pkg::TASK_OUT_W-1:0] outgoing_task,
    input logic [tsrr_pkg::SLICE_W-1:0]    slice_remaining,
    input logic [tsrr_pkg::TIME_W-1:0]     run_total,
    input logic [tsrr_pkg::COUNT_W-1:0]    switch_count
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick ready stayed high after an accepted beat");

    a_stay_same_task: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !switched |-> running_task == outgoing_task)
        else $error("running task changed without switch flag");

    a_switch_new_task: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && switched |-> running_task != outgoing_task)
        else $error("switch flag set but running task unchanged");

    a_slice_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> slice_remaining >= 3'd1 && slice_remaining <= 3'd5)
        else $error("slice remaining out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(running_task) && $stable(switched)
        && $stable(outgoing_task) && $stable(slice_remaining) && $stable(run_total)
        && $stable(switch_count))
        else $error("stalled result beat changed");

endmodule

bind time_slice_round_robin_scheduler_core tsrr_checker u_tsrr_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .tick_valid      (tick.valid),
    .tick_ready      (tick.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .running_task    (result.running_task),
    .switched        (result.switched),
    .outgoing_task   (result.outgoing_task),
    .slice_remaining (result.slice_remaining),
    .run_total       (result.outgoing_run_total),
    .switch_count    (result.outgoing_switch_count)
);

// File: sim/tsrr_sched_checker.sv
// Scheduler checker: follows the tick, result and register ports, predicts each result and compares.
module tsrr_sched_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsrr_pkg::CFG_DATA_W-1:0] cfg_data,
    tsrr_tick_if                            tick,
    tsrr_result_if                          result,
    output int                              errors,
    output int                              pending
);

    localparam int NTASK = tsrr_pkg::MAX_TASKS_DEF;

    typedef struct packed
    {
        logic [tsrr_pkg::TASK_OUT_W-1:0] running_task;
        logic                            switched;
        logic [tsrr_pkg::TASK_OUT_W-1:0] outgoing_task;
        logic [tsrr_pkg::SLICE_W-1:0]    slice_remaining;
        logic [tsrr_pkg::TIME_W-1:0]     outgoing_run_total;
        logic [tsrr_pkg::COUNT_W-1:0]    outgoing_switch_count;
    } sched_result_t;

    // Shadow registers
    logic [tsrr_pkg::TC_W-1:0]   task_count_cfg;
    logic [tsrr_pkg::PRIO_W-1:0] prio_cfg;
    logic [tsrr_pkg::EN_W-1:0]   enable_cfg;

    // Shadow scheduler state
    logic [tsrr_pkg::TASK_OUT_W-1:0] cur_task;
    logic [tsrr_pkg::SLICE_W-1:0]    slice_left;
    logic                            started;
    logic [tsrr_pkg::TIME_W-1:0]     launch_stamp [NTASK];
    logic [tsrr_pkg::TIME_W-1:0]     run_time     [NTASK];
    logic [tsrr_pkg::COUNT_W-1:0]    swap_count   [NTASK];

    sched_result_t due_q [$];
    int            mismatches;

    function automatic logic [tsrr_pkg::SLICE_W-1:0] slice_len(input int t);
        logic [tsrr_pkg::PRIO_BITS-1:0] p;
        p = prio_cfg[tsrr_pkg::PRIO_BITS*t +: tsrr_pkg::PRIO_BITS];
        return tsrr_pkg::SLICE_W'(tsrr_pkg::SLICE_BASE)
               - tsrr_pkg::SLICE_W'(int'(p) % tsrr_pkg::SLICE_BASE);
    endfunction

    // Scan forward from the running task over the slots in use.
    function automatic logic [tsrr_pkg::TASK_OUT_W-1:0] next_task();
        int n;
        int idx;
        int k;
        n = int'(task_count_cfg);
        if (n < 1)
            n = 1;
        if (n > NTASK)
            n = NTASK;
        idx = int'(cur_task);
        for (k = 0; k < n; k++)
        begin
            idx = (idx + 1) % n;
            if (enable_cfg[idx])
                return tsrr_pkg::TASK_OUT_W'(idx);
        end
        return cur_task;
    endfunction

    task automatic schedule_tick(input logic force_sw,
                                 input logic [tsrr_pkg::TIME_W-1:0] tick_now,
                                 output sched_result_t r);
        logic [tsrr_pkg::TASK_OUT_W-1:0] outgoing;
        logic [tsrr_pkg::TASK_OUT_W-1:0] nxt;
        logic                            expired;
        int                              i;
        outgoing   = cur_task;
        r.switched = 1'b0;
        if (!started)
        begin
            for (i = 0; i < NTASK; i++)
                launch_stamp[i] = tick_now;
            slice_left = slice_len(int'(cur_task));
            started    = 1'b1;
        end
        if (slice_left == '0)
            expired = 1'b1;
        else
        begin
            slice_left = slice_left - 1'b1;
            expired    = (slice_left == '0);
        end
        if (expired || force_sw)
        begin
            nxt = next_task();
            if (nxt != cur_task)
            begin
                run_time[outgoing] = run_time[outgoing] + (tick_now - launch_stamp[outgoing]);
                if (swap_count[outgoing] != '1)
                    swap_count[outgoing] = swap_count[outgoing] + 1'b1;
                launch_stamp[nxt] = tick_now;
                slice_left        = slice_len(int'(nxt));
                cur_task          = nxt;
                r.switched        = 1'b1;
            end
            else
                slice_left = slice_len(int'(cur_task));
        end
        r.running_task          = cur_task;
        r.outgoing_task         = outgoing;
        r.slice_remaining       = slice_left;
        r.outgoing_run_total    = run_time[outgoing];
        r.outgoing_switch_count = swap_count[outgoing];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        int            i;
        if (!rst_n)
        begin
            task_count_cfg = tsrr_pkg::TASK_COUNT_RST;
            prio_cfg       = tsrr_pkg::PRIORITY_TABLE_RST;
            enable_cfg     = tsrr_pkg::ENABLE_MASK_RST;
            cur_task       = '0;
            slice_left     = '0;
            started        = 1'b0;
            for (i = 0; i < NTASK; i++)
            begin
                launch_stamp[i] = '0;
                run_time[i]     = '0;
                swap_count[i]   = '0;
            end
            due_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due_q.size() == 0)
                begin
                    $display("%0t result beat with nothing expected: running_task %0h",
                             $time, result.running_task);
                    mismatches++;
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("running_task", 64'(want.running_task),
                                64'(result.running_task));
                    check_field("switched", 64'(want.switched), 64'(result.switched));
                    check_field("outgoing_task", 64'(want.outgoing_task),
                                64'(result.outgoing_task));
                    check_field("slice_remaining", 64'(want.slice_remaining),
                                64'(result.slice_remaining));
                    check_field("outgoing_run_total", want.outgoing_run_total,
                                result.outgoing_run_total);
                    check_field("outgoing_switch_count", 64'(want.outgoing_switch_count),
                                64'(result.outgoing_switch_count));
                end
            end
            if (tick.valid && tick.ready)
            begin
                schedule_tick(tick.force_switch, tick.tick_time, want);
                due_q.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tsrr_pkg::CFG_TASK_COUNT:
                        task_count_cfg = cfg_data[tsrr_pkg::TC_W-1:0];
                    tsrr_pkg::CFG_PRIORITY_TABLE:
                        prio_cfg       = cfg_data[tsrr_pkg::PRIO_W-1:0];
                    tsrr_pkg::CFG_ENABLE_MASK:
                        enable_cfg     = cfg_data[tsrr_pkg::EN_W-1:0];
                    default:            ;
                endcase
            end
        end
        errors  <= mismatches;
        pending <= due_q.size();
    end

endmodule

// File: sim/time_slice_round_robin_scheduler_core_tb.sv
// Testbench top: clock, reset, tick and register stimulus, result back-pressure and verdict.
module time_slice_round_robin_scheduler_core_tb;

    localparam logic [tsrr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int CONFIG_EVERY = 50;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we;
    logic [tsrr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tsrr_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              errors;
    int                              pending;
    int                              send_idle_pct;
    int                              recv_idle_pct;
    logic [tsrr_pkg::TIME_W-1:0]     tick_now;

    tsrr_tick_if   tick_ch();
    tsrr_result_if result_ch();

    time_slice_round_robin_scheduler_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    tsrr_sched_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_tick(input logic force_sw, input logic [tsrr_pkg::TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.force_switch <= force_sw;
        tick_ch.tick_time    <= t;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding result, then let the block go idle.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tsrr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsrr_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [tsrr_pkg::TC_W-1:0] tc,
                             input logic [tsrr_pkg::PRIO_W-1:0] prio,
                             input logic [tsrr_pkg::EN_W-1:0] en);
        settle();
        write_reg(tsrr_pkg::CFG_TASK_COUNT, tsrr_pkg::CFG_DATA_W'(tc));
        write_reg(tsrr_pkg::CFG_PRIORITY_TABLE, prio);
        write_reg(tsrr_pkg::CFG_ENABLE_MASK, tsrr_pkg::CFG_DATA_W'(en));
    endtask

    // Random settings; stray upper data bits and the spare index must be ignored.
    task automatic random_config();
        logic [tsrr_pkg::CFG_DATA_W-1:0] d;
        settle();
        d = tsrr_pkg::CFG_DATA_W'($urandom());
        if ($urandom_range(0, 3) == 0)
            d[tsrr_pkg::TC_W-1:0] = tsrr_pkg::TC_W'($urandom_range(0, 7));
        else
            d[tsrr_pkg::TC_W-1:0] = tsrr_pkg::TC_W'($urandom_range(1, 4));
        write_reg(tsrr_pkg::CFG_TASK_COUNT, d);
        write_reg(tsrr_pkg::CFG_PRIORITY_TABLE,
                  tsrr_pkg::CFG_DATA_W'($urandom_range(0, 4095)));
        d = tsrr_pkg::CFG_DATA_W'($urandom());
        if ($urandom_range(0, 2) == 0)
            d[tsrr_pkg::EN_W-1:0] = '1;
        write_reg(tsrr_pkg::CFG_ENABLE_MASK, d);
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_UNUSED, tsrr_pkg::CFG_DATA_W'($urandom()));
    endtask

    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % CONFIG_EVERY == CONFIG_EVERY - 1)
                random_config();
            case ($urandom_range(0, 19))
                0:       tick_now = {$urandom(), $urandom()};
                1:       tick_now = tick_now + {$urandom(), $urandom()};
                default: tick_now = tick_now + tsrr_pkg::TIME_W'($urandom_range(1, 5000));
            endcase
            send_tick($urandom_range(0, 3) == 0, tick_now);
        end
    endtask

    initial
    begin
        tick_ch.valid        <= 1'b0;
        tick_ch.force_switch <= 1'b0;
        tick_ch.tick_time    <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= tsrr_pkg::CFG_TASK_COUNT;
        cfg_data             <= '0;
        send_idle_pct = 17;
        recv_idle_pct = 60;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First tick loads the slice; run it out, then force across the time extremes.
        send_tick(1'b0, 64'd1000);
        send_tick(1'b0, 64'd1010);
        send_tick(1'b0, 64'd1020);
        send_tick(1'b0, 64'd1030);
        send_tick(1'b0, 64'd1040);
        send_tick(1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
        send_tick(1'b1, 64'h10);
        send_tick(1'b1, 64'h20);

        // Priorities 4..7 exercise the mod-5 slice reload.
        configure(3'd4, 12'hFAC, 4'hF);
        send_tick(1'b1, 64'h30);
        send_tick(1'b1, 64'h40);
        send_tick(1'b1, 64'h50);
        send_tick(1'b1, 64'h60);

        // Task count zero acts as one.
        configure(3'd0, 12'hFFF, 4'hF);
        write_reg(CFG_UNUSED, 12'hFFF);
        send_tick(1'b1, 64'h70);

        // Count above the slot limit, nothing enabled: hold the running task.
        configure(3'd7, 12'h000, 4'h0);
        send_tick(1'b1, 64'h80);
        send_tick(1'b0, 64'h90);

        configure(3'd4, 12'h000, 4'b1000);
        send_tick(1'b1, 64'hA0);

        // Running task now lies beyond the task count.
        configure(3'd2, 12'h000, 4'b0011);
        send_tick(1'b1, 64'hB0);

        // Running task disabled: it keeps its slice until expiry.
        configure(3'd4, 12'h000, 4'b0110);
        send_tick(1'b0, 64'hC0);
        send_tick(1'b0, 64'hD0);
        send_tick(1'b0, 64'hE0);
        send_tick(1'b0, 64'hF0);
        send_tick(1'b0, 64'h100);

        configure(3'd1, 12'hFFF, 4'hF);
        send_tick(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        tick_now = 64'h0;

        run_random(RANDOM_PER_PHASE);
        send_idle_pct = 60;
        recv_idle_pct = 17;
        run_random(RANDOM_PER_PHASE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);

        settle();
        if (errors == 0 && pending == 0)
            $display("PASS time_slice_round_robin_scheduler_core");
        else
            $display("FAIL time_slice_round_robin_scheduler_core");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("FAIL time_slice_round_robin_scheduler_core");
        $finish;
    end

endmodule
